// ===== rtl/core/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the convex hull scan block.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = ADDR_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] hull_x;
        logic signed [COORD_BITS-1:0] hull_y;
        logic                         hull_last;
    } t_out;

    // sign of (u - o) x (v - o)
    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
    } t_xres;

endpackage

`default_nettype wire

// ===== rtl/core/chs_cross.sv =====
// ----------------------------------------------------------------------------
// chs_cross
// Three-stage cross product sign unit: (u.x-o.x)*(v.y-o.y) - (u.y-o.y)*(v.x-o.x).
// ----------------------------------------------------------------------------
`default_nettype none

module chs_cross
    import chs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_go,
    input  wire t_point i_o,
    input  wire t_point i_u,
    input  wire t_point i_v,
    output t_xres       o_res
);

    logic                        r_v1, r_v2, r_v3;
    logic signed [DIFF_BITS-1:0] r_ux, r_uy, r_vx, r_vy;
    logic signed [PROD_BITS-1:0] r_p1, r_p2;
    logic signed [PROD_BITS:0]   w_diff;
    logic                        r_neg, r_zero;

    assign w_diff = {r_p1[PROD_BITS-1], r_p1} - {r_p2[PROD_BITS-1], r_p2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_go;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux   <= DIFF_BITS'(i_u.x) - DIFF_BITS'(i_o.x);
        r_uy   <= DIFF_BITS'(i_u.y) - DIFF_BITS'(i_o.y);
        r_vx   <= DIFF_BITS'(i_v.x) - DIFF_BITS'(i_o.x);
        r_vy   <= DIFF_BITS'(i_v.y) - DIFF_BITS'(i_o.y);
        r_p1   <= r_ux * r_vy;
        r_p2   <= r_uy * r_vx;
        r_neg  <= w_diff[PROD_BITS];
        r_zero <= (w_diff == '0);
    end

    assign o_res = '{done: r_v3, neg: r_neg, zero: r_zero};

endmodule

`default_nettype wire

// ===== rtl/core/convex_hull_scan.sv =====
// ----------------------------------------------------------------------------
// convex_hull_scan
// Graham scan convex hull over a stored point set, sorted in place in memory.
// ----------------------------------------------------------------------------
// Usage: present a point on i_point with start high; it is taken at a rising
// edge where busy is low, one point per cycle while loading. The point that
// carries last_point closes the set and busy rises on the next cycle. Up to
// MAX_POINTS points are kept; further points are dropped, though their
// last_point still starts the run.
// Results leave on o_hull, each valid for the single cycle in which o_strobe
// is high, clockwise from the pivot, hull_last on the final vertex. A set of
// fewer than three points is sent back unchanged. The receiver cannot stall.
// Sequencing: each compare-and-shift step of the insertion sort addresses the
// point memory, takes the read and then waits on the cross product unit; the
// stack scan waits on the same unit for each turn test, and the output reads
// each vertex from memory before it strobes it. The single read port of the
// point memory and the cross unit latency set this pace. busy falls after the
// last vertex has been strobed. Reset empties the set and the stack; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_hull_scan
    import chs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in  i_point,
    output logic      busy,
    output logic      o_strobe,
    output t_out      o_hull
);

    typedef enum logic [23:0] {
        ST_LOAD   = 24'h000001,
        ST_SKEY   = 24'h000002,
        ST_SKEY2  = 24'h000004,
        ST_SRD    = 24'h000008,
        ST_SCMP   = 24'h000010,
        ST_SWAIT  = 24'h000020,
        ST_SINS   = 24'h000040,
        ST_RLAST  = 24'h000080,
        ST_RLAST2 = 24'h000100,
        ST_RRD    = 24'h000200,
        ST_RCMP   = 24'h000400,
        ST_RWAIT  = 24'h000800,
        ST_VA     = 24'h001000,
        ST_VB     = 24'h002000,
        ST_VC     = 24'h004000,
        ST_VD     = 24'h008000,
        ST_CRD    = 24'h010000,
        ST_CGET   = 24'h020000,
        ST_CTEST  = 24'h040000,
        ST_CWAIT  = 24'h080000,
        ST_CPOP   = 24'h100000,
        ST_ERD    = 24'h200000,
        ST_EOUT   = 24'h400000,
        ST_IDLE2  = 24'h800000
    } t_state;

    t_state r_state, n_state;

    // point memory, sorted in place; stack memory of hull vertices
    t_point r_pmem [MAX_POINTS];
    t_point r_smem [MAX_POINTS];
    t_point r_prd, r_srd;
    logic [ADDR_BITS-1:0] p_raddr, p_waddr, s_raddr, s_waddr;
    logic                 p_we, s_we;
    t_point               p_wdata, s_wdata;

    logic [CNT_BITS-1:0] r_cnt, n_cnt, r_n, n_n, r_i, n_i, r_j, n_j;
    logic [CNT_BITS-1:0] r_d, n_d, r_k, n_k;
    logic [ADDR_BITS-1:0] r_lo, n_lo, r_hi, n_hi;
    t_point r_piv, n_piv, r_key, n_key, r_cur, n_cur, r_last, n_last;
    t_point r_top, n_top, r_sec, n_sec, r_c, n_c;
    logic   r_small, n_small;
    logic   r_strobe, n_strobe;
    t_out   r_out, n_out;

    logic   x_go;
    t_point x_o, x_u, x_v;
    t_xres  xres;

    logic   w_acc, w_room, w_newpiv, w_before, w_dupcur, w_duplast, w_push;
    logic [CNT_BITS-1:0] w_ecnt, w_cntnext;
    t_point w_in;

    chs_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (x_go),
        .i_o     (x_o),
        .i_u     (x_u),
        .i_v     (x_v),
        .o_res   (xres)
    );

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pmem[p_waddr] <= p_wdata;
        end
        r_prd <= r_pmem[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_waddr] <= s_wdata;
        end
        r_srd <= r_smem[s_raddr];
    end

    assign busy      = (r_state != ST_LOAD);
    assign w_acc     = start && !busy;
    assign w_room    = (r_cnt < CNT_BITS'(MAX_POINTS));
    assign w_in      = '{x: i_point.point_x, y: i_point.point_y};
    assign w_newpiv  = (r_cnt == '0) || (w_in.x < r_piv.x) ||
                       ((w_in.x == r_piv.x) && (w_in.y < r_piv.y));
    assign w_cntnext = w_room ? r_cnt + CNT_BITS'(1) : r_cnt;
    assign w_before  = xres.neg || (xres.zero && ((r_key.x < r_cur.x) ||
                       ((r_key.x == r_cur.x) && (r_key.y < r_cur.y))));
    assign w_dupcur  = (r_cur.x == r_piv.x) && (r_cur.y == r_piv.y);
    assign w_duplast = (r_last.x == r_piv.x) && (r_last.y == r_piv.y);
    assign w_ecnt    = r_small ? r_n : r_d;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_d      = r_d;
        n_k      = r_k;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_piv    = r_piv;
        n_key    = r_key;
        n_cur    = r_cur;
        n_last   = r_last;
        n_top    = r_top;
        n_sec    = r_sec;
        n_c      = r_c;
        n_small  = r_small;
        n_strobe = 1'b0;
        n_out    = r_out;
        p_raddr  = '0;
        p_waddr  = '0;
        p_wdata  = w_in;
        p_we     = 1'b0;
        s_raddr  = '0;
        s_waddr  = r_d[ADDR_BITS-1:0];
        s_wdata  = r_c;
        s_we     = 1'b0;
        x_go     = 1'b0;
        x_o      = r_piv;
        x_u      = r_key;
        x_v      = r_prd;
        w_push   = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                if (w_acc) begin
                    if (w_room) begin
                        p_we    = 1'b1;
                        p_waddr = r_cnt[ADDR_BITS-1:0];
                        if (w_newpiv) begin
                            n_piv = w_in;
                        end
                    end
                    n_cnt = w_cntnext;
                    if (i_point.last_point) begin
                        n_cnt   = '0;
                        n_n     = w_cntnext;
                        n_d     = '0;
                        n_k     = '0;
                        n_i     = CNT_BITS'(1);
                        n_small = (w_cntnext < CNT_BITS'(3));
                        n_state = (w_cntnext < CNT_BITS'(3)) ? ST_ERD : ST_SKEY;
                    end
                end
            end
            ST_SKEY: begin
                p_raddr = r_i[ADDR_BITS-1:0];
                n_state = ST_SKEY2;
            end
            ST_SKEY2: begin
                n_key   = r_prd;
                n_j     = r_i;
                n_state = ST_SRD;
            end
            ST_SRD: begin
                if (r_j == '0) begin
                    n_state = ST_SINS;
                end else begin
                    p_raddr = r_j[ADDR_BITS-1:0] - ADDR_BITS'(1);
                    n_state = ST_SCMP;
                end
            end
            ST_SCMP: begin
                n_cur   = r_prd;
                x_go    = 1'b1;
                n_state = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (xres.done) begin
                    if (w_before) begin
                        // shift the later point up one place
                        p_we    = 1'b1;
                        p_waddr = r_j[ADDR_BITS-1:0];
                        p_wdata = r_cur;
                        n_j     = r_j - CNT_BITS'(1);
                        n_state = ST_SRD;
                    end else begin
                        n_state = ST_SINS;
                    end
                end
            end
            ST_SINS: begin
                p_we    = 1'b1;
                p_waddr = r_j[ADDR_BITS-1:0];
                p_wdata = r_key;
                n_i     = r_i + CNT_BITS'(1);
                n_state = (r_i + CNT_BITS'(1) == r_n) ? ST_RLAST : ST_SKEY;
            end
            ST_RLAST: begin
                p_raddr = r_n[ADDR_BITS-1:0] - ADDR_BITS'(1);
                n_state = ST_RLAST2;
            end
            ST_RLAST2: begin
                n_last  = r_prd;
                n_j     = r_n - CNT_BITS'(1);
                n_state = ST_RRD;
            end
            ST_RRD: begin
                if (r_j <= CNT_BITS'(1)) begin
                    n_i     = '0;
                    n_state = ST_CRD;
                end else begin
                    p_raddr = r_j[ADDR_BITS-1:0] - ADDR_BITS'(1);
                    n_state = ST_RCMP;
                end
            end
            ST_RCMP: begin
                n_cur   = r_prd;
                x_go    = 1'b1;
                x_u     = r_prd;
                x_v     = r_last;
                n_state = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (xres.done) begin
                    n_i = '0;
                    if (xres.zero && !w_dupcur && !w_duplast) begin
                        n_j     = r_j - CNT_BITS'(1);
                        n_state = ST_RRD;
                    end else if (!w_dupcur) begin
                        // reverse the group on the final ray
                        n_lo    = r_j[ADDR_BITS-1:0];
                        n_hi    = r_n[ADDR_BITS-1:0] - ADDR_BITS'(1);
                        n_state = (r_j[ADDR_BITS-1:0] < r_n[ADDR_BITS-1:0] - ADDR_BITS'(1))
                                  ? ST_VA : ST_CRD;
                    end else begin
                        n_state = ST_CRD;
                    end
                end
            end
            ST_VA: begin
                p_raddr = r_lo;
                n_state = ST_VB;
            end
            ST_VB: begin
                n_cur   = r_prd;
                p_raddr = r_hi;
                n_state = ST_VC;
            end
            ST_VC: begin
                p_we    = 1'b1;
                p_waddr = r_lo;
                p_wdata = r_prd;
                n_state = ST_VD;
            end
            ST_VD: begin
                p_we    = 1'b1;
                p_waddr = r_hi;
                p_wdata = r_cur;
                n_lo    = r_lo + ADDR_BITS'(1);
                n_hi    = r_hi - ADDR_BITS'(1);
                n_state = (r_lo + ADDR_BITS'(1) < r_hi - ADDR_BITS'(1)) ? ST_VA : ST_CRD;
            end
            ST_CRD: begin
                p_raddr = r_i[ADDR_BITS-1:0];
                n_state = ST_CGET;
            end
            ST_CGET: begin
                n_c     = r_prd;
                n_state = ST_CTEST;
            end
            ST_CTEST: begin
                if (r_d >= CNT_BITS'(2)) begin
                    x_go    = 1'b1;
                    x_o     = r_sec;
                    x_u     = r_top;
                    x_v     = r_c;
                    n_state = ST_CWAIT;
                end else begin
                    w_push = 1'b1;
                end
            end
            ST_CWAIT: begin
                if (xres.done) begin
                    if (!xres.neg && !xres.zero) begin
                        // pop on a counterclockwise turn
                        n_d   = r_d - CNT_BITS'(1);
                        n_top = r_sec;
                        if (r_d >= CNT_BITS'(3)) begin
                            s_raddr = r_d[ADDR_BITS-1:0] - ADDR_BITS'(3);
                            n_state = ST_CPOP;
                        end else begin
                            n_state = ST_CTEST;
                        end
                    end else begin
                        w_push = 1'b1;
                    end
                end
            end
            ST_CPOP: begin
                n_sec   = r_srd;
                n_state = ST_CTEST;
            end
            ST_ERD: begin
                p_raddr = r_k[ADDR_BITS-1:0];
                s_raddr = r_k[ADDR_BITS-1:0];
                n_state = ST_EOUT;
            end
            ST_EOUT: begin
                n_strobe = 1'b1;
                n_out.hull_x    = r_small ? r_prd.x : r_srd.x;
                n_out.hull_y    = r_small ? r_prd.y : r_srd.y;
                n_out.hull_last = (r_k + CNT_BITS'(1) == w_ecnt);
                n_k      = r_k + CNT_BITS'(1);
                n_state  = (r_k + CNT_BITS'(1) == w_ecnt) ? ST_IDLE2 : ST_ERD;
            end
            ST_IDLE2: begin
                n_d     = '0;
                n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        if (w_push) begin
            s_we    = 1'b1;
            n_sec   = r_top;
            n_top   = r_c;
            n_d     = r_d + CNT_BITS'(1);
            n_i     = r_i + CNT_BITS'(1);
            n_k     = '0;
            n_state = (r_i + CNT_BITS'(1) == r_n) ? ST_ERD : ST_CRD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cnt    <= '0;
            r_n      <= '0;
            r_d      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_small  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_n      <= n_n;
            r_d      <= n_d;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_small  <= n_small;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_piv  <= n_piv;
        r_key  <= n_key;
        r_cur  <= n_cur;
        r_last <= n_last;
        r_top  <= n_top;
        r_sec  <= n_sec;
        r_c    <= n_c;
        r_out  <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_hull   = r_out;

`ifndef SYNTHESIS
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_point.last_point) |=> busy)
        else $error("busy did not rise after the closing transaction");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_EOUT))
        else $error("result strobe outside the output sequence");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d <= r_n)
        else $error("hull stack deeper than the point set");

    a_cross_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xres.done |-> (r_state == ST_SWAIT || r_state == ST_RWAIT || r_state == ST_CWAIT))
        else $error("cross product result with no waiting step");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_convex_hull_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convex_hull_scan
// Feeds point sets into the hull block, directed sets first and then random
// ones, with random start gaps but for the last points. A Graham scan in
// the bench predicts untyped hulls; each strobed vertex is checked by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_convex_hull_scan;
    import chs_pkg::*;

    localparam int LIMIT    = 1000000;
    localparam int N_RANDOM = 410;
    localparam int CALM     = 60;

    typedef struct {
        int x;
        int y;
        bit lst;
        int n_typed;
        int tx0, ty0, tx1, ty1;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_point;
    logic busy;
    logic o_strobe;
    t_out o_hull;

    convex_hull_scan u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_point  (i_point),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_hull   (o_hull)
    );

    always #2 i_clk = ~i_clk;

    t_out    hull_expected[$];
    longint  set_x[MAX_POINTS];
    longint  set_y[MAX_POINTS];
    int      set_len;
    int      errors;
    int      cycles;
    int      sets_done;
    int      vertices_seen;
    int      dropped_points;

    task automatic report(input string what, input t_out got, input t_out want);
        errors++;
        $display("MISMATCH %s: got (%0d,%0d,%0b) want (%0d,%0d,%0b) at %0t", what,
                 got.hull_x, got.hull_y, got.hull_last,
                 want.hull_x, want.hull_y, want.hull_last, $realtime);
    endtask

    // sign of a*b - c*d; operands are 17-bit so longint is exact
    function automatic int sgn_diff(longint a, longint b, longint c, longint d);
        longint v;
        v = a * b - c * d;
        return (v > 0) ? 1 : (v < 0) ? -1 : 0;
    endfunction

    function automatic bit cw_first(int p, int a, int b);
        longint ax, ay, bx, by;
        int s;
        ax = set_x[a] - set_x[p]; ay = set_y[a] - set_y[p];
        bx = set_x[b] - set_x[p]; by = set_y[b] - set_y[p];
        s = sgn_diff(ay, bx, by, ax);
        if (s != 0) return s > 0;
        if (ax != bx) return ax < bx;
        return ay < by;
    endfunction

    function automatic bit at_pivot(int p, int a);
        return set_x[a] == set_x[p] && set_y[a] == set_y[p];
    endfunction

    function automatic bit on_one_ray(int p, int a, int b);
        if (at_pivot(p, a) || at_pivot(p, b)) return 0;
        return sgn_diff(set_y[a] - set_y[p], set_x[b] - set_x[p],
                        set_y[b] - set_y[p], set_x[a] - set_x[p]) == 0;
    endfunction

    function automatic int turn_dir(int a, int b, int c);
        return sgn_diff(set_x[b] - set_x[a], set_y[c] - set_y[a],
                        set_y[b] - set_y[a], set_x[c] - set_x[a]);
    endfunction

    // Graham scan over the collected set; vertices go into out_q
    task automatic scan_hull(output t_out out_q[$]);
        int ord[MAX_POINTS];
        int stk[MAX_POINTS];
        int n, piv, i, j, k, key, lo, hi, tmp, depth;
        t_out v;
        n = set_len;
        out_q = {};
        if (n < 3) begin
            for (i = 0; i < n; i++) begin
                v.hull_x = COORD_BITS'(set_x[i]);
                v.hull_y = COORD_BITS'(set_y[i]);
                v.hull_last = (i == n - 1);
                out_q = {out_q, v};
            end
            return;
        end
        piv = 0;
        for (i = 1; i < n; i++)
            if (set_x[i] < set_x[piv] || (set_x[i] == set_x[piv] && set_y[i] < set_y[piv]))
                piv = i;
        ord[0] = piv;
        k = 1;
        for (i = 0; i < n; i++)
            if (i != piv) begin
                ord[k] = i;
                k++;
            end
        for (i = 2; i < n; i++) begin
            key = ord[i];
            j = i;
            while (j > 1 && cw_first(piv, key, ord[j-1])) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = key;
        end
        // reverse the last collinear group so the hull closes on the pivot
        j = n - 1;
        while (j > 1 && on_one_ray(piv, ord[j-1], ord[n-1])) j--;
        if (j > 1 && !at_pivot(piv, ord[j-1])) begin
            lo = j; hi = n - 1;
            while (lo < hi) begin
                tmp = ord[lo]; ord[lo] = ord[hi]; ord[hi] = tmp;
                lo++; hi--;
            end
        end
        depth = 0;
        for (i = 0; i < n; i++) begin
            while (depth >= 2 && turn_dir(ord[stk[depth-2]], ord[stk[depth-1]], ord[i]) > 0)
                depth--;
            stk[depth] = i;
            depth++;
        end
        for (i = 0; i < depth; i++) begin
            v.hull_x = COORD_BITS'(set_x[ord[stk[i]]]);
            v.hull_y = COORD_BITS'(set_y[ord[stk[i]]]);
            v.hull_last = (i == depth - 1);
            out_q = {out_q, v};
        end
    endtask

    // drive one point, hold it until taken, then update the prediction
    task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input bit lst, input bit gaps, input t_out typed[$]);
        t_out hull_q[$];
        start   <= 1'b1;
        i_point <= '{point_x: x, point_y: y, last_point: lst};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (set_len < MAX_POINTS) begin
            set_x[set_len] = x;
            set_y[set_len] = y;
            set_len++;
        end else begin
            dropped_points++;
        end
        if (lst) begin
            scan_hull(hull_q);
            if (typed.size() != 0) hull_q = typed;
            hull_expected = {hull_expected, hull_q};
            set_len = 0;
            sets_done++;
        end
        if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord(int mode);
        case (mode)
            0: return COORD_BITS'($urandom_range(0, 65535));
            1: return COORD_BITS'($signed($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_convex_hull_scan failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            vertices_seen++;
            if (hull_expected.size() == 0) begin
                want = '0;
                report("unexpected vertex", o_hull, want);
            end else begin
                want = hull_expected.pop_front();
                if (o_hull.hull_x !== want.hull_x) report("hull_x", o_hull, want);
                if (o_hull.hull_y !== want.hull_y) report("hull_y", o_hull, want);
                if (o_hull.hull_last !== want.hull_last) report("hull_last", o_hull, want);
            end
        end
    end

    t_row rows[$] = '{
        '{ 32767, -32768, 1, 1,  32767, -32768, 0, 0},
        '{-32768,  32767, 0, 0, 0, 0, 0, 0},
        '{ 32767, -32768, 1, 2, -32768,  32767, 32767, -32768},
        '{-32768, -32768, 0, 0, 0, 0, 0, 0},
        '{ 32767, -32768, 0, 0, 0, 0, 0, 0},
        '{     0,  32767, 1, 0, 0, 0, 0, 0},
        '{ 0, 0, 0, 0, 0, 0, 0, 0},
        '{ 2, 0, 0, 0, 0, 0, 0, 0},
        '{ 2, 2, 0, 0, 0, 0, 0, 0},
        '{ 0, 2, 0, 0, 0, 0, 0, 0},
        '{ 1, 0, 0, 0, 0, 0, 0, 0},
        '{ 0, 0, 0, 0, 0, 0, 0, 0},
        '{ 2, 2, 0, 0, 0, 0, 0, 0},
        '{ 1, 1, 1, 0, 0, 0, 0, 0},
        '{ 0, 0, 0, 0, 0, 0, 0, 0},
        '{ 3, 3, 0, 0, 0, 0, 0, 0},
        '{ 1, 1, 0, 0, 0, 0, 0, 0},
        '{ 2, 2, 1, 0, 0, 0, 0, 0},
        '{-5,  7, 0, 0, 0, 0, 0, 0},
        '{-5, -7, 0, 0, 0, 0, 0, 0},
        '{10,  0, 1, 0, 0, 0, 0, 0}
    };

    initial begin
        t_out typed[$];
        t_out v;
        int sent, set_size, mode, k;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_point = '0;
        errors = 0; cycles = 0; set_len = 0; sets_done = 0;
        vertices_seen = 0; dropped_points = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            typed = {};
            if (rows[r].n_typed >= 1) begin
                v.hull_x = COORD_BITS'(rows[r].tx0);
                v.hull_y = COORD_BITS'(rows[r].ty0);
                v.hull_last = (rows[r].n_typed == 1);
                typed = {typed, v};
            end
            if (rows[r].n_typed == 2) begin
                v.hull_x = COORD_BITS'(rows[r].tx1);
                v.hull_y = COORD_BITS'(rows[r].ty1);
                v.hull_last = 1'b1;
                typed = {typed, v};
            end
            send_point(COORD_BITS'(rows[r].x), COORD_BITS'(rows[r].y), rows[r].lst,
                       1'b1, typed);
        end

        // random sets, mostly small; now and then one that overflows the store
        typed = {};
        sent = 0;
        while (sent < N_RANDOM) begin
            set_size = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 72)
                                                    : $urandom_range(1, 14);
            mode = $urandom_range(0, 3);
            if (mode == 3) mode = 0;
            for (k = 0; k < set_size; k++) begin
                send_point(pick_coord(mode), pick_coord(mode), k == set_size - 1,
                           sent < N_RANDOM - CALM, typed);
                sent++;
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (hull_expected.size() != 0 || busy) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d point sets (%0d points dropped on a full store), %0d hull vertices checked",
                 sets_done, dropped_points, vertices_seen);
        if (errors == 0 && hull_expected.size() == 0) begin
            $display("tb_convex_hull_scan passed");
        end else begin
            $display("%0d mismatches, %0d vertices outstanding", errors, hull_expected.size());
            $display("tb_convex_hull_scan failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== convex_hull_scan.f =====
rtl/core/chs_pkg.sv
rtl/core/chs_cross.sv
rtl/core/convex_hull_scan.sv
dv/tb_convex_hull_scan.sv
